[rtl/fdfp_pkg.sv]
// Shared types and character constants for the framed decimal field parser.
// Depends on nothing; every other file of the block imports it.
package fdfp_pkg;

    // Characters that steer framing and field parsing.
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_AMP    = 8'h26;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;

    // Field positions; the position saturates at FIELD_LAST.
    localparam logic [2:0] FIELD_DISTANCE    = 3'd0;
    localparam logic [2:0] FIELD_DIRECTION   = 3'd1;
    localparam logic [2:0] FIELD_ORIENTATION = 3'd2;
    localparam logic [2:0] FIELD_LEAVING     = 3'd3;
    localparam logic [2:0] FIELD_LAST        = 3'd4;

    // Parse phase of the field in progress.
    typedef enum logic [1:0] {
        PH_SPACE  = 2'd0,
        PH_DIGITS = 2'd1,
        PH_STOP   = 2'd2
    } phase_t;

    // Complete parser state, carried between the state register and the step logic.
    typedef struct packed {
        logic       in_frame;
        logic [2:0] field_index;
        phase_t     phase;
        logic       negative;
        logic [7:0] accum;
        logic       any_nonzero;
        logic [7:0] distance;
        logic [7:0] direction;
        logic [7:0] orientation;
        logic       leaving;
    } parse_state_t;

endpackage

[rtl/fdfp_step.sv]
// Combinational update of the parser state for one received byte.
// Depends on fdfp_pkg for the state struct, phases and character codes.
module fdfp_step
    import fdfp_pkg::*;
(
    input  parse_state_t cur,
    input  logic [7:0]   rx_byte,
    output parse_state_t nxt,
    output logic         frame_done
);

    logic       is_blank;
    logic       is_sign;
    logic       is_digit;
    logic [7:0] digit;
    logic [7:0] accum_mac;
    logic [7:0] signed_val;

    // Character classes and the multiply-accumulate of one decimal digit.
    assign is_blank  = (rx_byte == CHAR_SPACE) ||
                       ((rx_byte >= CHAR_TAB) && (rx_byte <= CHAR_CR));
    assign is_sign   = (rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS);
    assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign digit     = rx_byte - CHAR_ZERO;
    assign accum_mac = {cur.accum[4:0], 3'b000} + {cur.accum[6:0], 1'b0} + digit;
    assign signed_val = cur.negative ? (8'd0 - cur.accum) : cur.accum;

    // Framing, field close and character parsing.
    always_comb
    begin
        nxt        = cur;
        frame_done = 1'b0;
        if (rx_byte == CHAR_DOLLAR)
        begin
            nxt.in_frame = 1'b1;
        end
        else if (cur.in_frame)
        begin
            if ((rx_byte == CHAR_COMMA) || (rx_byte == CHAR_AMP))
            begin
                // Store the finished field at its position; later fields are dropped.
                priority if (cur.field_index == FIELD_DISTANCE)
                    nxt.distance = signed_val;
                else if (cur.field_index == FIELD_DIRECTION)
                    nxt.direction = signed_val;
                else if (cur.field_index == FIELD_ORIENTATION)
                    nxt.orientation = signed_val;
                else if (cur.field_index == FIELD_LEAVING)
                    nxt.leaving = cur.any_nonzero;
                else
                    nxt.leaving = cur.leaving;
                if (cur.field_index < FIELD_LAST)
                    nxt.field_index = cur.field_index + 3'd1;
                nxt.phase       = PH_SPACE;
                nxt.negative    = 1'b0;
                nxt.accum       = 8'd0;
                nxt.any_nonzero = 1'b0;
                if (rx_byte == CHAR_AMP)
                begin
                    frame_done      = 1'b1;
                    nxt.in_frame    = 1'b0;
                    nxt.field_index = FIELD_DISTANCE;
                end
            end
            else
            begin
                unique case (cur.phase)
                    PH_SPACE:
                    begin
                        // Skip blanks, take a sign, fall into digit parsing, or stop on any other byte.
                        if (is_blank)
                            nxt.phase = PH_SPACE;
                        else if (is_sign)
                        begin
                            nxt.negative = (rx_byte == CHAR_MINUS);
                            nxt.phase    = PH_DIGITS;
                        end
                        else if (is_digit)
                        begin
                            nxt.accum       = accum_mac;
                            nxt.any_nonzero = cur.any_nonzero || (digit != 8'd0);
                            nxt.phase       = PH_DIGITS;
                        end
                        else
                            nxt.phase = PH_STOP;
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            nxt.accum       = accum_mac;
                            nxt.any_nonzero = cur.any_nonzero || (digit != 8'd0);
                        end
                        else
                            nxt.phase = PH_STOP;
                    end
                    PH_STOP:
                    begin
                        nxt.phase = PH_STOP;
                    end
                    default:
                    begin
                        nxt.phase = cur.phase;
                    end
                endcase
            end
        end
    end

endmodule

[rtl/framed_decimal_field_parser_core.sv]
// Framed decimal field parser: top level with the input register, state and result register.
// Depends on fdfp_pkg and fdfp_step.
//
// Usage: one ASCII byte enters per beat on the input channel (in_valid, in_stall,
// rx_byte). Every byte gives exactly one result beat on the output channel
// (out_valid, out_stall, frame_done, distance, direction, orientation, leaving_flag),
// which shows the stored fields after that byte and flags a frame-closing '&'.
// A byte accepted into the input register is parsed from there into the state and
// result registers, which present its result. Throughput: one byte per cycle
// while the receiver does not stall; the parse of one byte is a single pass of
// the step logic between the input register and the state and result registers.
// When the receiver stalls, the result register holds its beat; in_stall rises
// at once if the input register holds a byte, else that register still takes
// one more byte first. Reset clears all parser state and stored fields to zero and
// empties both registers; the block is ready directly after reset.
module framed_decimal_field_parser_core
    import fdfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              frame_done,
    output logic [7:0]        distance,
    output logic signed [7:0] direction,
    output logic signed [7:0] orientation,
    output logic              leaving_flag
);

    logic         in_valid_reg;
    logic [7:0]   rx_byte_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         done_next;
    logic         out_valid_reg;
    logic         done_reg;
    logic         slot_free;
    logic         advance;

    // Handshake: the parse step runs when the result slot is free or being emptied.
    assign slot_free = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && slot_free;
    assign in_stall  = in_valid_reg && !slot_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            rx_byte_reg <= rx_byte;
    end

    // Parse step for the registered byte.
    fdfp_step u_step (
        .cur        (state_reg),
        .rx_byte    (rx_byte_reg),
        .nxt        (state_next),
        .frame_done (done_next)
    );

    // Parser state and result register; the stored fields are read straight from state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
                done_reg  <= done_next;
            end
            if (slot_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_done   = done_reg;
    assign distance     = state_reg.distance;
    assign direction    = $signed(state_reg.direction);
    assign orientation  = $signed(state_reg.orientation);
    assign leaving_flag = state_reg.leaving;

    // A parsed byte always lands in the result register.
    assert property (@(posedge clk) disable iff (!rst_n) advance |=> out_valid_reg)
        else $error("parsed byte did not produce a result beat");

    // A frame-done beat leaves the parser outside a frame at the first field.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |->
            (!state_reg.in_frame && (state_reg.field_index == FIELD_DISTANCE)))
        else $error("frame_done without frame reset");

    // The field position never passes its saturation point.
    assert property (@(posedge clk) disable iff (!rst_n) state_reg.field_index <= FIELD_LAST)
        else $error("field index out of range");

    // State only moves together with a new result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> (state_reg == $past(state_reg)))
        else $error("parser state changed without a parsed byte");

endmodule
